// ----- rtl/dcb_pkg.sv -----
package dcb_pkg;

  // default sizes
  localparam int MAX_LENGTH_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // averager count in the long form
  localparam int NUM_STAGES = 4;

  // last averager index in each form
  localparam logic [1:0] STG_SHORT_LAST = 2'd1;
  localparam logic [1:0] STG_LONG_LAST  = 2'd3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MODE     = 2'd1;

  localparam logic [CFG_DATA_W-1:0] WINDOW_LENGTH_RST = 7'd32;
  localparam logic                  LONG_MODE_RST     = 1'b1;

  // back end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } dcb_state_t;

  // control from the register block to the back end
  typedef struct packed {
    logic clear;
    logic long_mode;
  } dcb_ctrl_t;

endpackage

// ----- rtl/dcb_front.sv -----
module dcb_front #(
  parameter int SAMPLE_BITS = dcb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          q_valid,
  output logic signed [SAMPLE_BITS-1:0] q_sample,
  input  logic                          q_pop
);

  // two-entry queue between the input channel and the back end
  logic signed [SAMPLE_BITS-1:0] q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign in_stall = (cnt_r == 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_sample = q_mem[rd_ptr_r];

  assign push = in_valid && !in_stall;
  assign pop  = q_pop && q_valid;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= in_sample_in;
    end
  end

endmodule

// ----- rtl/dcb_back.sv -----
module dcb_back #(
  parameter int MAX_LENGTH  = dcb_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS = dcb_pkg::SAMPLE_BITS_DEF,
  localparam int FW = $clog2(MAX_LENGTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dcb_pkg::dcb_ctrl_t            ctrl,
  input  logic [FW-1:0]                 d_len,
  input  logic                          q_valid,
  input  logic signed [SAMPLE_BITS-1:0] q_sample,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS:0]   out_sample_out
);

  localparam int SB  = SAMPLE_BITS;
  localparam int NS  = dcb_pkg::NUM_STAGES;
  localparam int LW  = $clog2(MAX_LENGTH);
  localparam int PW  = (LW < 1) ? 1 : LW;
  localparam int SW  = SB + LW + 1;
  localparam int NW  = SB - 1 + LW;
  localparam int K   = 2 * LW + SB - 1;
  localparam int PRW = NW + K;

  // reciprocal table: ceil(2^K / d), exact floor division for every sum magnitude
  logic [K-1:0] recip_tab [MAX_LENGTH + 1];
  for (genvar d = 0; d <= MAX_LENGTH; d++) begin : g_recip
    localparam longint unsigned DV = (d < 2) ? 64'd1 : 64'(d);
    localparam longint unsigned RV = ((64'd1 << K) + DV - 64'd1) / DV;
    assign recip_tab[d] = RV[K-1:0];
  end

  dcb_pkg::dcb_state_t state_r, state_nxt;
  logic [1:0]              stg_r, stg_nxt;
  logic signed [SB-1:0]    x_r, x_nxt;
  logic signed [SB-1:0]    dly_r, dly_nxt;
  logic signed [SW-1:0]    sum_r [NS];
  logic signed [SW-1:0]    sum_nxt [NS];
  logic [PW-1:0]           wp_r, wp_nxt;
  logic [PW-1:0]           cp_r, cp_nxt;
  logic [FW-1:0]           fill_r, fill_nxt;
  logic [PRW-1:0]          prod_r, prod_nxt;
  logic                    neg_r, neg_nxt;
  logic [K-1:0]            recip_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SB:0]      out_r, out_nxt;

  logic signed [SB-1:0]    old_q [NS];
  logic signed [SB-1:0]    near_q;
  logic signed [SB-1:0]    comp_q;
  logic signed [SB-1:0]    comp_mem [MAX_LENGTH];

  logic [NS-1:0]           win_we;
  logic                    comp_we;
  logic                    rd_en;
  logic [PW-1:0]           wp_next;
  logic [PW-1:0]           cp_next;
  logic                    old_ok;
  logic                    dly_ok;
  logic signed [SW-1:0]    cur_sum;
  logic [NW-1:0]           mag;
  logic [SB-1:0]           quo;
  logic signed [SB-1:0]    oldest;
  logic signed [SB-1:0]    delayed;
  logic [1:0]              last_stg;

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

  // pointer successors and window fill tests
  assign wp_next  = (wp_r == PW'(d_len - FW'(1))) ? '0 : wp_r + PW'(1);
  assign cp_next  = (cp_r == PW'(d_len - FW'(2))) ? '0 : cp_r + PW'(1);
  assign old_ok   = (fill_r >= d_len);
  assign dly_ok   = (fill_r >= d_len - FW'(1));
  assign last_stg = ctrl.long_mode ? dcb_pkg::STG_LONG_LAST : dcb_pkg::STG_SHORT_LAST;

  // magnitude for the floor division: -s-1 for negative sums
  assign cur_sum = sum_r[stg_r];
  assign mag     = cur_sum[SW-1] ? NW'(~cur_sum) : NW'(cur_sum);
  assign quo     = prod_r[K +: SB];
  assign oldest  = old_ok ? old_q[stg_r] : '0;
  assign delayed = ctrl.long_mode ? (dly_ok ? comp_q : '0) : dly_r;

  // sequencer: one averager per pass of acc, mul, div
  always_comb begin
    state_nxt     = state_r;
    stg_nxt       = stg_r;
    x_nxt         = x_r;
    dly_nxt       = dly_r;
    sum_nxt       = sum_r;
    wp_nxt        = wp_r;
    cp_nxt        = cp_r;
    fill_nxt      = fill_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    win_we        = '0;
    comp_we       = 1'b0;
    unique case (state_r)
      dcb_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          rd_en     = 1'b1;
          x_nxt     = q_sample;
          stg_nxt   = 2'd0;
          state_nxt = dcb_pkg::ST_ACC;
        end
      end
      dcb_pkg::ST_ACC: begin
        win_we[stg_r]  = 1'b1;
        sum_nxt[stg_r] = sum_r[stg_r] + SW'(x_r) - SW'(oldest);
        if (stg_r == 2'd0) begin
          dly_nxt = dly_ok ? near_q : '0;
        end
        state_nxt = dcb_pkg::ST_MUL;
      end
      dcb_pkg::ST_MUL: begin
        prod_nxt  = PRW'(mag) * PRW'(recip_r);
        neg_nxt   = cur_sum[SW-1];
        state_nxt = dcb_pkg::ST_DIV;
      end
      dcb_pkg::ST_DIV: begin
        x_nxt = neg_r ? ~quo : quo;
        if (stg_r == last_stg) begin
          state_nxt = dcb_pkg::ST_FIN;
        end else begin
          stg_nxt   = stg_r + 2'd1;
          state_nxt = dcb_pkg::ST_ACC;
        end
      end
      dcb_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = (SB+1)'(delayed) - (SB+1)'(x_r);
          comp_we       = ctrl.long_mode;
          wp_nxt        = wp_next;
          if (ctrl.long_mode) begin
            cp_nxt = cp_next;
          end
          fill_nxt  = (fill_r == FW'(MAX_LENGTH)) ? fill_r : fill_r + FW'(1);
          state_nxt = dcb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dcb_pkg::ST_IDLE;
      end
    endcase
    // register write empties every window
    if (ctrl.clear) begin
      for (int i = 0; i < NS; i++) begin
        sum_nxt[i] = '0;
      end
      wp_nxt   = '0;
      cp_nxt   = '0;
      fill_nxt = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dcb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      wp_r        <= '0;
      cp_r        <= '0;
      fill_r      <= '0;
      for (int i = 0; i < NS; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wp_r        <= wp_nxt;
      cp_r        <= cp_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    stg_r   <= stg_nxt;
    x_r     <= x_nxt;
    dly_r   <= dly_nxt;
    prod_r  <= prod_nxt;
    neg_r   <= neg_nxt;
    out_r   <= out_nxt;
    recip_r <= recip_tab[d_len];
  end

  // one window memory per averager, stage zero also gives the delayed input
  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic signed [SB-1:0] win_mem [MAX_LENGTH];
    logic signed [SB-1:0] old_rd_r;
    always_ff @(posedge clk) begin
      if (win_we[g]) begin
        win_mem[wp_r] <= x_r;
      end
      if (rd_en) begin
        old_rd_r <= win_mem[wp_r];
      end
    end
    assign old_q[g] = old_rd_r;
    if (g == 0) begin : g_near
      always_ff @(posedge clk) begin
        if (rd_en) begin
          near_q <= win_mem[wp_next];
        end
      end
    end
  end

  // compensation delay line for the long form
  always_ff @(posedge clk) begin
    if (comp_we) begin
      comp_mem[cp_r] <= dly_r;
    end
    if (rd_en) begin
      comp_q <= comp_mem[cp_r];
    end
  end

endmodule

// ----- rtl/dc_blocker_moving_average_core.sv -----
// Linear-phase dc blocker: input minus a cascade of moving averages of length D.
// Input channel: in_valid / in_stall with one signed sample per transaction.
// Output channel: out_valid / out_stall with one 17-bit result per transaction.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 = window
// length, 1 = long mode); a write to either one empties all windows and delay
// lines. An item waits in the input queue until the back end fetches it; the
// back end sequencer then runs an add, a reciprocal multiply and a floor step
// for each averager, then writes the output register, and only then takes the
// next item: the shared multiplier and the serial chain of averagers serve
// one item at a time.
// A two-entry input queue takes transactions while the back end is busy.
// Reset empties the queue, the output register and all windows; registers
// return to window length 32 and long form.
// When the receiver stalls, the result holds in the output register and the
// back end finishes the next item, then waits; the input queue fills and
// raises in_stall.
module dc_blocker_moving_average_core #(
  parameter int MAX_LENGTH  = dcb_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_BITS = dcb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS:0]         out_sample_out,
  input  logic                                cfg_we,
  input  logic [dcb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dcb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int FW = $clog2(MAX_LENGTH + 1);

  logic [dcb_pkg::CFG_DATA_W-1:0] wl_r, wl_nxt;
  logic                           long_r, long_nxt;
  logic [FW-1:0]                  d_len;
  dcb_pkg::dcb_ctrl_t             ctrl;
  logic                           q_valid;
  logic signed [SAMPLE_BITS-1:0]  q_sample;
  logic                           q_pop;

  // configuration registers
  always_comb begin
    wl_nxt     = wl_r;
    long_nxt   = long_r;
    ctrl.clear = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        dcb_pkg::REG_WINDOW_LENGTH: begin
          wl_nxt     = cfg_data;
          ctrl.clear = 1'b1;
        end
        dcb_pkg::REG_LONG_MODE: begin
          long_nxt   = cfg_data[0];
          ctrl.clear = 1'b1;
        end
        default: begin
        end
      endcase
    end
    ctrl.long_mode = long_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r   <= dcb_pkg::WINDOW_LENGTH_RST;
      long_r <= dcb_pkg::LONG_MODE_RST;
    end else begin
      wl_r   <= wl_nxt;
      long_r <= long_nxt;
    end
  end

  // window length clamped to the supported range
  always_comb begin
    priority if (wl_r < dcb_pkg::CFG_DATA_W'(2)) begin
      d_len = FW'(2);
    end else if (32'(wl_r) > MAX_LENGTH) begin
      d_len = FW'(MAX_LENGTH);
    end else begin
      d_len = FW'(wl_r);
    end
  end

  dcb_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_in (in_sample_in),
    .q_valid      (q_valid),
    .q_sample     (q_sample),
    .q_pop        (q_pop)
  );

  dcb_back #(
    .MAX_LENGTH  (MAX_LENGTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .d_len          (d_len),
    .q_valid        (q_valid),
    .q_sample       (q_sample),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out)
  );

endmodule

// ----- rtl/dcb_checker.sv -----
module dcb_checker #(
  parameter int SAMPLE_BITS = dcb_pkg::SAMPLE_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [SAMPLE_BITS:0]           out_sample_out,
  input logic                           cfg_we,
  input logic [dcb_pkg::CFG_IDX_W-1:0]  cfg_index
);

  // transactions taken but not yet delivered
  logic [2:0] pend_r, pend_nxt;
  logic       in_acc;
  logic       out_acc;
  logic       cfg_seen;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign cfg_seen = cfg_we && ((cfg_index == dcb_pkg::REG_WINDOW_LENGTH) ||
                               (cfg_index == dcb_pkg::REG_LONG_MODE));
  assign pend_nxt = pend_r + 3'(in_acc) - 3'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out))
    else $error("stalled result changed");

  // nothing is delivered that was not taken
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (pend_r != 3'd0))
    else $error("result without input");

  // queue, back end and output register hold at most four items
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("too many items in flight");

  // reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not empty after reset");

  // configuration only while idle, so nothing is pending then
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_seen && (pend_r == 3'd0) |=> !out_valid)
    else $error("result after write to an idle block");

endmodule

bind dc_blocker_moving_average_core dcb_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_dcb_checker (.*);
